/* rtl/rmc_pkg.sv */
package rmc_pkg;

    // Storage and arithmetic constants
    localparam int DEFAULT_MAX_VERTICES = 32;
    localparam int COST_W               = 32;
    localparam int VTX_W                = 5;
    localparam int CNT_W                = 6;
    localparam logic signed [COST_W-1:0] COST_MAX = 32'sh7FFF_FFFF;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_SET_COST = 2'd0,
        OP_ADD_EDGE = 2'd1,
        OP_RUN      = 2'd2,
        OP_CLEAR    = 2'd3
    } opcode_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take_in;   // apply the accepted input beat
        logic init;      // rewind the scan; the cost copy comes with take_in of a run
        logic scan;      // relax the edges of one source vertex
        logic emit;      // load one result into the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic at_last;   // scan or emit index sits on the final vertex in use
        logic changed;   // some best cost dropped during the current pass
        logic out_busy;  // output register holds a beat that is not taken
    } dp_stat_t;

endpackage

/* rtl/rmc_if.sv */
interface rmc_in_if;
    import rmc_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [VTX_W-1:0]   vertex;
    logic [VTX_W-1:0]   source_vertex;
    logic signed [COST_W-1:0] cost;

    modport source (output valid, output opcode, output vertex, output source_vertex,
                    output cost, input ready);
    modport sink (input valid, input opcode, input vertex, input source_vertex,
                  input cost, output ready);
endinterface

interface rmc_out_if;
    import rmc_pkg::*;

    logic               valid;
    logic               ready;
    logic [VTX_W-1:0]   out_vertex;
    logic signed [COST_W-1:0] best_cost;
    logic               last;

    modport source (output valid, output out_vertex, output best_cost, output last,
                    input ready);
    modport sink (input valid, input out_vertex, input best_cost, input last,
                  output ready);
endinterface

interface rmc_cfg_if;
    import rmc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CNT_W-1:0]   vertex_count;

    modport source (output valid, output vertex_count, input ready);
    modport sink (input valid, input vertex_count, output ready);
endinterface

/* rtl/rmc_ctrl.sv */
module rmc_ctrl
    import rmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic [1:0] in_opcode,
    output logic      in_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    if (opcode_t'(in_opcode) == OP_RUN)
                    begin
                        cmd.init   = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // Passes repeat until one leaves every best cost unchanged.
                cmd.scan = 1'b1;
                if (stat.at_last && !stat.changed)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit = 1'b1;
                    if (stat.at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/rmc_datapath.sv */
module rmc_datapath
    import rmc_pkg::*;
#(
    parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
)
(
    input  logic      clk,
    input  logic      rst_n,
    rmc_in_if.sink    in_ch,
    rmc_out_if.source out_ch,
    rmc_cfg_if.sink   cfg_ch,
    input  ctrl_cmd_t cmd,
    output dp_stat_t  stat
);

    localparam int DEPTH = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
    localparam int IW    = $clog2(DEPTH);

    logic signed [COST_W-1:0] costs_reg [DEPTH];
    logic signed [COST_W-1:0] best_reg  [DEPTH];
    logic signed [COST_W-1:0] best_next [DEPTH];
    logic [DEPTH-1:0]         edge_reg  [DEPTH];
    logic [IW-1:0]            idx_reg;
    logic                     changed_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     out_valid_reg;
    logic [VTX_W-1:0]         out_vertex_reg;
    logic signed [COST_W-1:0] out_cost_reg;
    logic                     out_last_reg;

    logic [CNT_W-1:0]         active_cnt;
    logic [IW-1:0]            last_idx;
    logic [DEPTH-1:0]         in_use;
    logic [DEPTH-1:0]         row;
    logic signed [COST_W-1:0] src_cost;
    logic                     step_change;
    logic                     tgt_ok;
    logic                     src_ok;
    logic [IW-1:0]            tgt_idx;
    logic [IW-1:0]            src_idx;

    // Vertex count clamped to the range in use
    always_comb
    begin
        if (count_reg == '0)
        begin
            active_cnt = CNT_W'(1);
        end
        else if (count_reg > CNT_W'(DEPTH))
        begin
            active_cnt = CNT_W'(DEPTH);
        end
        else
        begin
            active_cnt = count_reg;
        end
        last_idx = IW'(active_cnt - CNT_W'(1));
        for (int t = 0; t < DEPTH; t++)
        begin
            in_use[t] = CNT_W'(t) < active_cnt;
        end
    end

    // Address checks for loads
    assign tgt_ok  = {1'b0, in_ch.vertex} < CNT_W'(DEPTH);
    assign src_ok  = {1'b0, in_ch.source_vertex} < CNT_W'(DEPTH);
    assign tgt_idx = in_ch.vertex[IW-1:0];
    assign src_idx = in_ch.source_vertex[IW-1:0];

    // One relaxation step: the best cost of the scanned source flows to its targets.
    always_comb
    begin
        src_cost    = best_reg[idx_reg];
        row         = edge_reg[idx_reg] & in_use;
        step_change = 1'b0;
        for (int t = 0; t < DEPTH; t++)
        begin
            best_next[t] = best_reg[t];
            if (row[t] && (src_cost < best_reg[t]))
            begin
                best_next[t] = src_cost;
                step_change  = 1'b1;
            end
        end
    end

    assign stat.at_last  = idx_reg == last_idx;
    assign stat.changed  = changed_reg | step_change;
    assign stat.out_busy = out_valid_reg & ~out_ch.ready;

    // Cost, edge and best stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                costs_reg[i] <= COST_MAX;
                best_reg[i]  <= COST_MAX;
                edge_reg[i]  <= '0;
            end
        end
        else if (cmd.take_in)
        begin
            case (opcode_t'(in_ch.opcode))
                OP_SET_COST:
                begin
                    if (tgt_ok)
                    begin
                        costs_reg[tgt_idx] <= in_ch.cost;
                    end
                end
                OP_ADD_EDGE:
                begin
                    if (tgt_ok && src_ok)
                    begin
                        edge_reg[src_idx][tgt_idx] <= 1'b1;
                    end
                end
                OP_RUN:
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        best_reg[i] <= costs_reg[i];
                    end
                end
                default:
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        costs_reg[i] <= COST_MAX;
                        best_reg[i]  <= COST_MAX;
                        edge_reg[i]  <= '0;
                    end
                end
            endcase
        end
        else if (cmd.scan)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                best_reg[i] <= best_next[i];
            end
        end
    end

    // Scan and emit index with the pass change flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            changed_reg <= 1'b0;
        end
        else if (cmd.init)
        begin
            idx_reg     <= '0;
            changed_reg <= 1'b0;
        end
        else if (cmd.scan || cmd.emit)
        begin
            idx_reg     <= stat.at_last ? '0 : idx_reg + IW'(1);
            changed_reg <= stat.at_last ? 1'b0 : stat.changed;
        end
    end

    // Vertex count register
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(32);
        end
        else if (cfg_ch.valid)
        begin
            count_reg <= cfg_ch.vertex_count;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_vertex_reg <= VTX_W'(idx_reg);
            out_cost_reg   <= best_reg[idx_reg];
            out_last_reg   <= stat.at_last;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_vertex = out_vertex_reg;
    assign out_ch.best_cost  = out_cost_reg;
    assign out_ch.last       = out_last_reg;

endmodule

/* rtl/reachable_min_cost.sv */
// Channel | Role | Beat contents
// in_ch   | sink   | opcode, vertex, source_vertex, cost
// out_ch  | source | out_vertex, best_cost, last
// cfg_ch  | sink   | vertex_count, always ready
//
// Set cost, add edge and clear are accepted whenever the block is idle.
// A run makes passes (at most N) over the N vertices in use, one source row relaxed per
// cycle, until a pass changes nothing, then emits N results; input is held off meanwhile.
// Reset (rst_n, asynchronous) sets all costs to the largest value and empties the edges.
// A stalled output beat holds in the output register and pauses emission.
module reachable_min_cost
    import rmc_pkg::*;
#(
    parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
)
(
    input  logic      clk,
    input  logic      rst_n,
    rmc_in_if.sink    in_ch,
    rmc_out_if.source out_ch,
    rmc_cfg_if.sink   cfg_ch
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Sequencer
    rmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Stores and relaxation logic
    rmc_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule

/* bench/reachable_min_cost_tb.sv */
module reachable_min_cost_tb;
    import rmc_pkg::*;

    // One expected result beat.
    typedef struct {
        logic [VTX_W-1:0]         vtx;
        logic signed [COST_W-1:0] cost;
        logic                     last;
    } result_beat_t;

    // Scoreboard: mirrors the cost and edge stores and predicts each run.
    class cost_board;
        logic signed [COST_W-1:0] costs[32];
        logic [31:0]              edges[32];
        int unsigned              count_reg;
        result_beat_t             pending[$];
        int                       errors;
        int                       beats_checked;

        function void reset_stores();
            for (int i = 0; i < 32; i++)
            begin
                costs[i] = COST_MAX;
                edges[i] = '0;
            end
        endfunction

        function void power_on();
            reset_stores();
            count_reg = 32;
            errors = 0;
            beats_checked = 0;
        endfunction

        // Apply an accepted input beat and queue any results it causes.
        function void note_input(opcode_t op, logic [4:0] v, logic [4:0] s,
                                 logic signed [31:0] c);
            int unsigned n;
            logic [31:0] in_use, reach, grown;
            logic signed [31:0] best[32];
            result_beat_t b;
            case (op)
                OP_SET_COST: costs[v] = c;
                OP_ADD_EDGE: edges[s][v] = 1'b1;
                OP_CLEAR:    reset_stores();
                OP_RUN:
                begin
                    n = (count_reg == 0) ? 1 : (count_reg > 32 ? 32 : count_reg);
                    in_use = (n == 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 1);
                    for (int i = 0; i < 32; i++)
                        best[i] = COST_MAX;
                    for (int u = 0; u < n; u++)
                    begin
                        reach = 32'd1 << u;
                        do
                        begin
                            grown = reach;
                            for (int w = 0; w < n; w++)
                                if (reach[w])
                                    grown |= edges[w] & in_use;
                            if (grown == reach)
                                break;
                            reach = grown;
                        end while (1);
                        for (int t = 0; t < n; t++)
                            if (reach[t] && costs[u] < best[t])
                                best[t] = costs[u];
                    end
                    for (int t = 0; t < n; t++)
                    begin
                        b.vtx = t[4:0];
                        b.cost = best[t];
                        b.last = (t + 1 == n);
                        pending.insert(pending.size(), b);
                    end
                end
            endcase
        endfunction

        // Compare one accepted result beat against the oldest expectation.
        function void check_result(logic [4:0] v, logic signed [31:0] c, logic l);
            result_beat_t e;
            beats_checked++;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat: out_vertex %0d best_cost %0d", v, c);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (v !== e.vtx)
            begin
                $error("out_vertex: expected %0d, got %0d", e.vtx, v);
                errors++;
            end
            if (c !== e.cost)
            begin
                $error("best_cost: expected %0d, got %0d", e.cost, c);
                errors++;
            end
            if (l !== e.last)
            begin
                $error("last: expected %0d, got %0d", e.last, l);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    rmc_in_if  in_ch();
    rmc_out_if out_ch();
    rmc_cfg_if cfg_ch();

    cost_board board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;
    int items_sent = 0;
    int runs_sent = 0;

    reachable_min_cost uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always #5 clk = ~clk;

    // Check result beats and watch for a hung run at each rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                board.check_result(out_ch.out_vertex, out_ch.best_cost, out_ch.last);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("reachable_min_cost_tb failed");
                $finish;
            end
        end
    end

    // Receiver stalls at random, changing on the falling edge.
    always @(negedge clk)
        out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);

    // Send one input beat, with a random idle gap before it. Valid stays high
    // after the beat is taken; the next beat or the drain decides what follows.
    task automatic send_beat(opcode_t op, logic [4:0] v, logic [4:0] s,
                             logic signed [31:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.vertex <= v;
        in_ch.source_vertex <= s;
        in_ch.cost <= c;
        do
            @(posedge clk);
        while (!in_ch.ready);
        board.note_input(op, v, s, c);
        items_sent++;
        if (op == OP_RUN)
            runs_sent++;
        @(negedge clk);
    endtask

    // Wait until every expected result beat has come, plus settling time.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (8)
            @(negedge clk);
    endtask

    // Write the vertex count register while the block is idle.
    task automatic write_count(logic [5:0] n);
        cfg_ch.valid <= 1'b1;
        cfg_ch.vertex_count <= n;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        board.count_reg = 32'(n);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_cost();
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(20)) - 10;
            default: return $signed($urandom());
        endcase
    endfunction

    // Random graph: mostly costs and edges among low vertices, then a run.
    task automatic random_phase(int items, int unsigned span);
        int r;
        for (int i = 0; i < items; i++)
        begin
            r = $urandom_range(99);
            if (r < 40)
                send_beat(OP_SET_COST, 5'($urandom_range(span - 1)), 5'($urandom()),
                          rand_cost());
            else if (r < 80)
                send_beat(OP_ADD_EDGE, 5'($urandom_range(span - 1)),
                          5'($urandom_range(span - 1)), $urandom());
            else if (r < 83)
                send_beat(OP_CLEAR, 5'($urandom()), 5'($urandom()), $urandom());
            else if (r < 88)
                send_beat(OP_ADD_EDGE, 5'($urandom()), 5'($urandom()), $urandom());
            else
                send_beat(OP_RUN, 5'($urandom()), 5'($urandom()), $urandom());
        end
        send_beat(OP_RUN, 5'($urandom()), 5'($urandom()), $urandom());
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_SET_COST;
        in_ch.vertex = '0;
        in_ch.source_vertex = '0;
        in_ch.cost = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.vertex_count = '0;
        board.power_on();
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset state, extremes, chain, self loop, duplicates.
        send_beat(OP_RUN, 5'd0, 5'd0, 32'sd0);
        send_beat(OP_SET_COST, 5'd31, 5'd0, 32'sh8000_0000);
        send_beat(OP_SET_COST, 5'd0, 5'd31, 32'sh7FFF_FFFE);
        send_beat(OP_SET_COST, 5'd3, 5'd0, -32'sd5);
        send_beat(OP_ADD_EDGE, 5'd1, 5'd31, 32'sd0);
        send_beat(OP_ADD_EDGE, 5'd2, 5'd1, 32'sd0);
        send_beat(OP_ADD_EDGE, 5'd3, 5'd2, 32'sd0);
        send_beat(OP_ADD_EDGE, 5'd0, 5'd3, 32'sd0);
        send_beat(OP_ADD_EDGE, 5'd0, 5'd3, 32'sd0);
        send_beat(OP_ADD_EDGE, 5'd5, 5'd5, 32'sd0);
        send_beat(OP_ADD_EDGE, 5'd30, 5'd0, 32'sd0);
        send_beat(OP_RUN, 5'd31, 5'd31, 32'shFFFF_FFFF);
        drain();
        // Vertex 31 falls out of use, so its edge into vertex 1 may not be used.
        write_count(6'd4);
        send_beat(OP_RUN, 5'd0, 5'd0, 32'sd0);
        drain();
        write_count(6'd0);
        send_beat(OP_RUN, 5'd0, 5'd0, 32'sd0);
        drain();
        write_count(6'd63);
        send_beat(OP_RUN, 5'd0, 5'd0, 32'sd0);
        send_beat(OP_CLEAR, 5'd0, 5'd0, 32'sd0);
        send_beat(OP_RUN, 5'd0, 5'd0, 32'sd0);
        drain();

        // Random phases over several idling modes and vertex counts.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            case (ph)
                0: write_count(6'd1);
                3: write_count(6'd32);
                5: write_count(6'd2);
                default: write_count(6'($urandom_range(3, 10)));
            endcase
            random_phase(13, (ph == 3) ? 32 : 12);
            drain();
        end

        $display("Sent %0d input beats including %0d runs; checked %0d result beats.",
                 items_sent, runs_sent, board.beats_checked);
        $display("Covered vertex counts 0, 1, 2, 4, 32, 63 and random small graphs.");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("reachable_min_cost_tb passed");
        else
            $display("reachable_min_cost_tb failed");
        $finish;
    end

endmodule
